// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define OHNT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define OHNT_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== rtl/ohnt_pkg.sv =====
package ohnt_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int MASK_REGS = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_AREA_ID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HELLO_INT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT0_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT3_MASK = 3'd5;

  localparam logic [3:0] ST_REFRESHED = 4'd0;
  localparam logic [3:0] ST_ADDED     = 4'd1;
  localparam logic [3:0] ST_VERSION   = 4'd2;
  localparam logic [3:0] ST_AREA      = 4'd3;
  localparam logic [3:0] ST_AUTH      = 4'd4;
  localparam logic [3:0] ST_HEADER    = 4'd5;
  localparam logic [3:0] ST_TYPE      = 4'd6;
  localparam logic [3:0] ST_MASK      = 4'd7;
  localparam logic [3:0] ST_INTERVAL  = 4'd8;
  localparam logic [3:0] ST_FULL      = 4'd9;
  localparam logic [3:0] ST_TICK      = 4'd10;
  localparam logic [3:0] ST_NO_PORT   = 4'd11;

  localparam logic [7:0]  HELLO_VERSION = 8'd2;
  localparam logic [7:0]  KIND_HELLO    = 8'd1;
  localparam logic [15:0] AGE_MAX       = 16'hFFFF;
  localparam logic [5:0]  COUNT_MAX     = 6'h3F;

  typedef struct packed {
    logic [31:0] ip;
    logic [31:0] router;
    logic [15:0] interval;
    logic [15:0] age;
  } entry_t;

endpackage

// ===== rtl/ohnt_entry_ram.sv =====
module ohnt_entry_ram #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [ADDR_W-1:0]    wr_addr_i,
  input  ohnt_pkg::entry_t     wr_data_i,
  input  logic [ADDR_W-1:0]    rd_addr_i,
  output ohnt_pkg::entry_t     rd_data_o
);

  ohnt_pkg::entry_t mem_q [DEPTH];
  ohnt_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/ospf_hello_neighbour_table_core.sv =====
// A hello runs two checks, then a read and a compare per slot, then loads the result; a tick
// reads and ages each of the NUM_PORTS*ENTRIES_PER_PORT entries, and each dying entry adds
// a read and a compare of every entry for the router id sweep; all reads use the one entry
// RAM read port. A new item is taken only when idle, also while the last result still waits.
// Reset clears the controller, valid bits and config registers; the entry RAM is not cleared.
`include "assert_macros.svh"

module ospf_hello_neighbour_table_core #(
  parameter int NUM_PORTS        = 4,
  parameter int ENTRIES_PER_PORT = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ohnt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [1:0]                     port_i,
  input  logic [7:0]                     version_i,
  input  logic [31:0]                    pkt_area_i,
  input  logic [15:0]                    auth_kind_i,
  input  logic                           header_ok_i,
  input  logic [7:0]                     pkt_kind_i,
  input  logic [31:0]                    source_ip_i,
  input  logic [31:0]                    sender_id_i,
  input  logic [31:0]                    sender_mask_i,
  input  logic [15:0]                    sender_interval_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [3:0]                     status_o,
  output logic                           topology_changed_o,
  output logic [5:0]                     removed_count_o,
  output logic                           id_changed_o
);

  localparam int TOTAL  = NUM_PORTS * ENTRIES_PER_PORT;
  localparam int IDX_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int SLOT_W = (ENTRIES_PER_PORT > 1) ? $clog2(ENTRIES_PER_PORT) : 1;
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TOTAL - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES_PER_PORT - 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_CHK_AREA = 10'b0000000010,
    S_CHK_MASK = 10'b0000000100,
    S_SCAN_RD  = 10'b0000001000,
    S_SCAN_EV  = 10'b0000010000,
    S_AGE_RD   = 10'b0000100000,
    S_AGE_EV   = 10'b0001000000,
    S_KILL_RD  = 10'b0010000000,
    S_KILL_EV  = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] area_q, area_d;
  logic [15:0] hello_int_q, hello_int_d;
  logic [31:0] mask_q [ohnt_pkg::MASK_REGS];
  logic [31:0] mask_d [ohnt_pkg::MASK_REGS];

  logic        req_q;
  logic [1:0]  port_q;
  logic [7:0]  version_q;
  logic [31:0] pkt_area_q;
  logic [15:0] auth_q;
  logic        hdr_q;
  logic [7:0]  kind_q;
  logic [31:0] sip_q;
  logic [31:0] sid_q;
  logic [31:0] smask_q;
  logic [15:0] sint_q;

  logic [TOTAL-1:0]  valid_q, valid_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [IDX_W-1:0]  ent_q, ent_d;
  logic [IDX_W-1:0]  kill_q, kill_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic              free_found_q, free_found_d;
  logic [31:0]       dead_id_q, dead_id_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [3:0]        res_status_q, res_status_d;
  logic              res_topo_q, res_topo_d;
  logic              res_idc_q, res_idc_d;

  logic        out_valid_q, out_valid_d;
  logic [3:0]  out_status_q, out_status_d;
  logic        out_topo_q, out_topo_d;
  logic [5:0]  out_removed_q, out_removed_d;
  logic        out_idc_q, out_idc_d;

  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  ohnt_pkg::entry_t   ram_wr_data;
  logic [IDX_W-1:0]   ram_rd_addr;
  ohnt_pkg::entry_t   rd_entry;

  logic [31:0] cmp_a, cmp_b;
  logic        cmp_eq;
  logic [IDX_W-1:0] scan_idx;
  logic [15:0] age_inc;
  logic [17:0] age_limit;
  logic        dies;
  logic        free_now;
  logic        advance_ent;
  logic        in_accept;

  ohnt_entry_ram #(
    .DEPTH  (TOTAL),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (rd_entry)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  assign scan_idx  = IDX_W'(32'(port_q) * ENTRIES_PER_PORT) + IDX_W'(slot_q);
  assign age_inc   = (rd_entry.age == ohnt_pkg::AGE_MAX) ? rd_entry.age : rd_entry.age + 16'd1;
  assign age_limit = {2'b00, rd_entry.interval} + {1'b0, rd_entry.interval, 1'b0};
  assign dies      = ({2'b00, age_inc} > age_limit);
  assign free_now  = !free_found_q && !valid_q[scan_idx];

  always_comb begin
    case (state_q)
      S_CHK_AREA: begin
        cmp_a = pkt_area_q;
        cmp_b = area_q;
      end
      S_CHK_MASK: begin
        cmp_a = smask_q;
        cmp_b = mask_q[port_q];
      end
      S_SCAN_EV: begin
        cmp_a = sip_q;
        cmp_b = rd_entry.ip;
      end
      S_KILL_EV: begin
        cmp_a = dead_id_q;
        cmp_b = rd_entry.router;
      end
      default: begin
        cmp_a = 32'd0;
        cmp_b = 32'd0;
      end
    endcase
  end

  assign cmp_eq = (cmp_a == cmp_b);

  always_comb begin
    area_d      = area_q;
    hello_int_d = hello_int_q;
    mask_d      = mask_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ohnt_pkg::CFG_AREA_ID:   area_d = cfg_data_i;
        ohnt_pkg::CFG_HELLO_INT: hello_int_d = cfg_data_i[15:0];
        default: begin
          if (cfg_index_i inside {[ohnt_pkg::CFG_PORT0_MASK:ohnt_pkg::CFG_PORT3_MASK]}) begin
            mask_d[2'(cfg_index_i - ohnt_pkg::CFG_PORT0_MASK)] = cfg_data_i;
          end
        end
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    slot_d       = slot_q;
    ent_d        = ent_q;
    kill_d       = kill_q;
    free_idx_d   = free_idx_q;
    free_found_d = free_found_q;
    dead_id_d    = dead_id_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_topo_d   = res_topo_q;
    res_idc_d    = res_idc_q;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = scan_idx;
    ram_wr_data  = '{ip: sip_q, router: sid_q, interval: sint_q, age: 16'd0};
    ram_rd_addr  = ent_q;
    advance_ent  = 1'b0;

    out_valid_d   = out_valid_q && out_stall_i;
    out_status_d  = out_status_q;
    out_topo_d    = out_topo_q;
    out_removed_d = out_removed_q;
    out_idc_d     = out_idc_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cnt_d      = 6'd0;
          res_topo_d = 1'b0;
          res_idc_d  = 1'b0;
          ent_d      = '0;
          state_d    = req_type_i ? S_AGE_RD : S_CHK_AREA;
        end
      end
      S_CHK_AREA: begin
        state_d = S_DONE;
        if (version_q != ohnt_pkg::HELLO_VERSION) begin
          res_status_d = ohnt_pkg::ST_VERSION;
        end else if (!cmp_eq) begin
          res_status_d = ohnt_pkg::ST_AREA;
        end else if (auth_q != 16'd0) begin
          res_status_d = ohnt_pkg::ST_AUTH;
        end else if (!hdr_q) begin
          res_status_d = ohnt_pkg::ST_HEADER;
        end else if (kind_q != ohnt_pkg::KIND_HELLO) begin
          res_status_d = ohnt_pkg::ST_TYPE;
        end else if (32'(port_q) >= NUM_PORTS) begin
          res_status_d = ohnt_pkg::ST_NO_PORT;
        end else begin
          state_d = S_CHK_MASK;
        end
      end
      S_CHK_MASK: begin
        state_d = S_DONE;
        if (!cmp_eq) begin
          res_status_d = ohnt_pkg::ST_MASK;
        end else if (sint_q != hello_int_q) begin
          res_status_d = ohnt_pkg::ST_INTERVAL;
        end else begin
          slot_d       = '0;
          free_found_d = 1'b0;
          state_d      = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        ram_rd_addr = scan_idx;
        state_d     = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (valid_q[scan_idx] && cmp_eq) begin
          ram_wr_en    = 1'b1;
          res_idc_d    = (rd_entry.router != sid_q);
          res_status_d = ohnt_pkg::ST_REFRESHED;
          state_d      = S_DONE;
        end else begin
          if (free_now) begin
            free_idx_d   = scan_idx;
            free_found_d = 1'b1;
          end
          if (slot_q == LAST_SLOT) begin
            state_d = S_DONE;
            if (free_found_q || free_now) begin
              ram_wr_en    = 1'b1;
              ram_wr_addr  = free_now ? scan_idx : free_idx_q;
              valid_d[ram_wr_addr] = 1'b1;
              res_status_d = ohnt_pkg::ST_ADDED;
              res_topo_d   = 1'b1;
            end else begin
              res_status_d = ohnt_pkg::ST_FULL;
            end
          end else begin
            slot_d  = slot_q + 1'b1;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_AGE_RD: begin
        ram_rd_addr = ent_q;
        state_d     = S_AGE_EV;
      end
      S_AGE_EV: begin
        if (valid_q[ent_q]) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = ent_q;
          ram_wr_data = '{ip: rd_entry.ip, router: rd_entry.router,
                          interval: rd_entry.interval, age: age_inc};
        end
        if (valid_q[ent_q] && dies) begin
          dead_id_d = rd_entry.router;
          kill_d    = '0;
          state_d   = S_KILL_RD;
        end else begin
          advance_ent = 1'b1;
        end
      end
      S_KILL_RD: begin
        ram_rd_addr = kill_q;
        state_d     = S_KILL_EV;
      end
      S_KILL_EV: begin
        if (valid_q[kill_q] && cmp_eq) begin
          valid_d[kill_q] = 1'b0;
          if (cnt_q != ohnt_pkg::COUNT_MAX) begin
            cnt_d = cnt_q + 6'd1;
          end
        end
        if (kill_q == LAST_IDX) begin
          advance_ent = 1'b1;
        end else begin
          kill_d  = kill_q + 1'b1;
          state_d = S_KILL_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d   = 1'b1;
          out_status_d  = res_status_q;
          out_topo_d    = res_topo_q || (cnt_q != 6'd0);
          out_removed_d = cnt_q;
          out_idc_d     = res_idc_q;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (advance_ent) begin
      if (ent_q == LAST_IDX) begin
        res_status_d = ohnt_pkg::ST_TICK;
        state_d      = S_DONE;
      end else begin
        ent_d   = ent_q + 1'b1;
        state_d = S_AGE_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      area_q       <= 32'd0;
      hello_int_q  <= 16'd5;
      for (int p = 0; p < ohnt_pkg::MASK_REGS; p++) begin
        mask_q[p] <= 32'd0;
      end
      valid_q      <= '0;
      slot_q       <= '0;
      ent_q        <= '0;
      kill_q       <= '0;
      free_found_q <= 1'b0;
      cnt_q        <= 6'd0;
      res_topo_q   <= 1'b0;
      res_idc_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      area_q       <= area_d;
      hello_int_q  <= hello_int_d;
      mask_q       <= mask_d;
      valid_q      <= valid_d;
      slot_q       <= slot_d;
      ent_q        <= ent_d;
      kill_q       <= kill_d;
      free_found_q <= free_found_d;
      cnt_q        <= cnt_d;
      res_topo_q   <= res_topo_d;
      res_idc_q    <= res_idc_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q      <= req_type_i;
      port_q     <= port_i;
      version_q  <= version_i;
      pkt_area_q <= pkt_area_i;
      auth_q     <= auth_kind_i;
      hdr_q      <= header_ok_i;
      kind_q     <= pkt_kind_i;
      sip_q      <= source_ip_i;
      sid_q      <= sender_id_i;
      smask_q    <= sender_mask_i;
      sint_q     <= sender_interval_i;
    end
    free_idx_q    <= free_idx_d;
    dead_id_q     <= dead_id_d;
    res_status_q  <= res_status_d;
    out_status_q  <= out_status_d;
    out_topo_q    <= out_topo_d;
    out_removed_q <= out_removed_d;
    out_idc_q     <= out_idc_d;
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign topology_changed_o = out_topo_q;
  assign removed_count_o    = out_removed_q;
  assign id_changed_o       = out_idc_q;

  `OHNT_ASSERT_IMPL(a_removed_on_tick, out_valid_o && (removed_count_o != 6'd0),
    (status_o == ohnt_pkg::ST_TICK) && topology_changed_o, "removal outside a tick")
  `OHNT_ASSERT_IMPL(a_idc_on_refresh, out_valid_o && id_changed_o,
    status_o == ohnt_pkg::ST_REFRESHED, "router id change outside a refresh")
  `OHNT_ASSERT(a_accept_leaves_idle, in_accept |=> (state_q != S_IDLE) && (req_q ? 
    (state_q == S_AGE_RD) : (state_q == S_CHK_AREA)), "accepted beat not started")

endmodule
